[rtl/nls_pkg.sv]
// shared types, constants and character class helpers for the numeric literal scanner
`default_nettype none

package nls_pkg;

    // length cap: the configured maximum, limited by the 8-bit length field
    localparam int MaxLen = 255;
    localparam int LenCapInt = (MaxLen < 255) ? MaxLen : 255;
    localparam logic [7:0] LenCap = LenCapInt[7:0];

    // result kinds
    localparam logic [2:0] KindInt       = 3'd0;
    localparam logic [2:0] KindFloat     = 3'd1;
    localparam logic [2:0] KindInvalid   = 3'd2;
    localparam logic [2:0] KindDoubleSep = 3'd3;
    localparam logic [2:0] KindTrailSep  = 3'd4;
    localparam logic [2:0] KindNotNumber = 3'd5;

    // character codes
    localparam logic [7:0] ChUnderscore = 8'h5F;
    localparam logic [7:0] ChPoint      = 8'h2E;
    localparam logic [7:0] ChLowerE     = 8'h65;
    localparam logic [7:0] ChUpperE     = 8'h45;
    localparam logic [7:0] ChPlus       = 8'h2B;
    localparam logic [7:0] ChMinus      = 8'h2D;

    typedef enum logic [1:0] {
        ModeIdle  = 2'd0,
        ModeScan  = 2'd1,
        ModeError = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        HeadNone   = 2'd0,
        HeadMarker = 2'd1,
        HeadSign   = 2'd2
    } t_head;

    // input beat
    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] token_length;
    } t_out_item;

    // scanner state carried from character to character
    typedef struct packed {
        t_mode      mode;
        logic       seen_point;
        logic       seen_exponent;
        logic       last_sep;
        logic       last_point;
        t_head      head;
        logic [7:0] run_length;
        logic [2:0] pend_error;
    } t_scan_state;

    localparam t_scan_state ScanReset = '{
        mode:          ModeIdle,
        seen_point:    1'b0,
        seen_exponent: 1'b0,
        last_sep:      1'b0,
        last_point:    1'b0,
        head:          HeadNone,
        run_length:    8'd0,
        pend_error:    3'd0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A))
            || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // characters an error span keeps swallowing
    function automatic logic is_span_char(input logic [7:0] c);
        return is_alnum(c) || (c == ChPoint) || (c == ChUnderscore);
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] len);
        return (len < LenCap) ? len + 8'd1 : len;
    endfunction

endpackage

`default_nettype wire

[rtl/nls_step.sv]
// one-character step of the scanner: next state and optional result
`default_nettype none

module nls_step (
    input  wire nls_pkg::t_scan_state i_state,
    input  wire nls_pkg::t_in_item    i_item,
    output nls_pkg::t_scan_state      o_state,
    output logic                      o_res_valid,
    output nls_pkg::t_out_item        o_res
);

    logic [7:0] c;
    logic       swallow;
    logic [2:0] term_error;

    assign c = i_item.char_code;
    assign swallow = nls_pkg::is_span_char(c);
    assign term_error = i_state.last_sep ? nls_pkg::KindTrailSep : nls_pkg::KindInvalid;

    always_comb begin
        o_state = i_state;
        o_res_valid = 1'b0;
        o_res.kind = i_state.pend_error;
        o_res.token_length = i_state.run_length;

        if (i_item.cmd) begin
            // start of a new attempt drops anything in progress
            o_state = nls_pkg::ScanReset;
            if (!nls_pkg::is_digit(c)) begin
                o_res_valid = 1'b1;
                o_res.kind = nls_pkg::KindNotNumber;
                o_res.token_length = 8'd0;
            end else begin
                o_state.mode = nls_pkg::ModeScan;
                o_state.run_length = 8'd1;
            end
        end else begin
            case (i_state.mode)
                nls_pkg::ModeError: begin
                    // error span: swallow or close
                    if (swallow) begin
                        o_state.run_length = nls_pkg::bump(i_state.run_length);
                    end else begin
                        o_state = nls_pkg::ScanReset;
                        o_res_valid = 1'b1;
                    end
                end
                nls_pkg::ModeScan: begin
                    if (nls_pkg::is_digit(c)) begin
                        o_state.last_sep = 1'b0;
                        o_state.last_point = 1'b0;
                        o_state.head = nls_pkg::HeadNone;
                        o_state.run_length = nls_pkg::bump(i_state.run_length);
                    end else if (c == nls_pkg::ChUnderscore) begin
                        // separator rules
                        if (i_state.last_sep) begin
                            o_state.mode = nls_pkg::ModeError;
                            o_state.pend_error = nls_pkg::KindDoubleSep;
                        end else if (i_state.last_point
                                     || (i_state.head != nls_pkg::HeadNone)) begin
                            o_state.mode = nls_pkg::ModeError;
                            o_state.pend_error = nls_pkg::KindInvalid;
                        end else begin
                            o_state.last_sep = 1'b1;
                        end
                        o_state.run_length = nls_pkg::bump(i_state.run_length);
                    end else if ((c == nls_pkg::ChPoint) && !i_state.seen_point
                                 && !i_state.seen_exponent) begin
                        o_state.seen_point = 1'b1;
                        o_state.last_point = 1'b1;
                        o_state.last_sep = 1'b0;
                        o_state.head = nls_pkg::HeadNone;
                        o_state.run_length = nls_pkg::bump(i_state.run_length);
                    end else if (((c == nls_pkg::ChLowerE) || (c == nls_pkg::ChUpperE))
                                 && !i_state.seen_exponent) begin
                        o_state.seen_exponent = 1'b1;
                        o_state.head = nls_pkg::HeadMarker;
                        o_state.last_sep = 1'b0;
                        o_state.last_point = 1'b0;
                        o_state.run_length = nls_pkg::bump(i_state.run_length);
                    end else if (((c == nls_pkg::ChPlus) || (c == nls_pkg::ChMinus))
                                 && (i_state.head == nls_pkg::HeadMarker)) begin
                        o_state.head = nls_pkg::HeadSign;
                        o_state.run_length = nls_pkg::bump(i_state.run_length);
                    end else if (i_state.last_sep || (i_state.head != nls_pkg::HeadNone)) begin
                        // bad ending: the terminator is offered to the error span
                        if (swallow) begin
                            o_state.mode = nls_pkg::ModeError;
                            o_state.pend_error = term_error;
                            o_state.run_length = nls_pkg::bump(i_state.run_length);
                        end else begin
                            o_state = nls_pkg::ScanReset;
                            o_res_valid = 1'b1;
                            o_res.kind = term_error;
                        end
                    end else begin
                        // clean ending
                        o_state = nls_pkg::ScanReset;
                        o_res_valid = 1'b1;
                        o_res.kind = (i_state.seen_point || i_state.seen_exponent)
                                   ? nls_pkg::KindFloat : nls_pkg::KindInt;
                    end
                end
                default: begin
                    // idle: continuation characters are ignored
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/numeric_literal_scanner_core.sv]
// Numeric literal scanner: one character per beat in, kind and length out.
// Input channel: i_valid / o_stall with i_data (cmd, char_code). A beat with
//   cmd set starts a new literal; cmd clear continues the current one.
// Output channel: o_valid / i_stall with o_data (kind, token_length). A
//   beat comes out when a literal or error span ends, or at once for a start
//   on a non-digit. The ending character is not part of the literal.
// Throughput: one character per cycle while the receiver takes results. The
//   scanner state is updated by one short step between the input register
//   and the result register, so nothing limits the rate but the handshake.
// Path: an accepted character is held in the input register; its result, if any,
//   is written to the result register when the held character moves on.
// Stalls: while a result waits, the held character waits too, whether or not
//   it gives a result, and o_stall is high whenever a held character cannot move
//   on, so one character is buffered at most.
// Reset: synchronous, active low; the scanner returns to idle with all
//   flags and the length cleared, and both registers empty.
`default_nettype none

module numeric_literal_scanner_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire nls_pkg::t_in_item i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output nls_pkg::t_out_item  o_data
);

    logic                 r_in_valid;
    nls_pkg::t_in_item    r_in;
    nls_pkg::t_scan_state r_state;
    nls_pkg::t_scan_state n_state;
    logic                 r_out_valid;
    nls_pkg::t_out_item   r_out;
    nls_pkg::t_out_item   n_out;
    logic                 n_out_valid;
    logic                 advance;
    logic                 in_take;

    // step logic on the held character
    nls_step u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .o_state     (n_state),
        .o_res_valid (n_out_valid),
        .o_res       (n_out)
    );

    // held character moves on when the result slot is free or being emptied
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= nls_pkg::ScanReset;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= n_out_valid;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_data;
        end
        if (advance && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[bench/nls_checker.sv]
// result checker for the numeric literal scanner: predicts each result beat and compares
`timescale 1ns / 1ps

module nls_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_stall,
    input  nls_pkg::t_in_item  i_in_data,
    input  wire               i_out_valid,
    input  wire               i_out_stall,
    input  nls_pkg::t_out_item i_out_data,
    output int                o_fail_count,
    output int                o_results_due
);
    import nls_pkg::*;

    // predicted scanner state
    t_mode      lit_mode;
    logic       has_point;
    logic       has_exp;
    logic       after_sep;
    logic       after_point;
    t_head      exp_head;
    logic [7:0] span_len;
    logic [2:0] span_kind;

    t_out_item  due_q[$];
    int         fails = 0;

    function automatic bit dec_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic bit word_char(input logic [7:0] c);
        return dec_digit(c) || ((c >= 8'h61) && (c <= 8'h7A))
            || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic void lengthen();
        if (span_len < LenCap) begin
            span_len = span_len + 8'd1;
        end
    endfunction

    function automatic void back_to_idle();
        lit_mode    = ModeIdle;
        has_point   = 1'b0;
        has_exp     = 1'b0;
        after_sep   = 1'b0;
        after_point = 1'b0;
        exp_head    = HeadNone;
        span_len    = 8'd0;
        span_kind   = 3'd0;
    endfunction

    function automatic void open_span(input logic [2:0] k);
        lit_mode  = ModeError;
        span_kind = k;
    endfunction

    // one character step; a result comes out when a literal or span closes
    task automatic scan_beat(input t_in_item beat, output bit produced, output t_out_item res);
        logic [7:0] ch;
        bit         offer;
        ch       = beat.char_code;
        produced = 1'b0;
        res      = '0;
        offer    = 1'b0;
        if (beat.cmd) begin
            back_to_idle();
            if (!dec_digit(ch)) begin
                produced         = 1'b1;
                res.kind         = KindNotNumber;
                res.token_length = 8'd0;
            end else begin
                lit_mode = ModeScan;
                span_len = 8'd1;
            end
        end else if (lit_mode == ModeScan) begin
            if (dec_digit(ch)) begin
                after_sep   = 1'b0;
                after_point = 1'b0;
                exp_head    = HeadNone;
                lengthen();
            end else if (ch == ChUnderscore) begin
                if (after_sep) begin
                    open_span(KindDoubleSep);
                end else if (after_point || exp_head != HeadNone) begin
                    open_span(KindInvalid);
                end else begin
                    after_sep = 1'b1;
                end
                lengthen();
            end else if (ch == ChPoint && !has_point && !has_exp) begin
                has_point   = 1'b1;
                after_point = 1'b1;
                after_sep   = 1'b0;
                exp_head    = HeadNone;
                lengthen();
            end else if ((ch == ChLowerE || ch == ChUpperE) && !has_exp) begin
                has_exp     = 1'b1;
                exp_head    = HeadMarker;
                after_sep   = 1'b0;
                after_point = 1'b0;
                lengthen();
            end else if ((ch == ChPlus || ch == ChMinus) && exp_head == HeadMarker) begin
                exp_head = HeadSign;
                lengthen();
            end else if (after_sep) begin
                open_span(KindTrailSep);
                offer = 1'b1;
            end else if (exp_head != HeadNone) begin
                // marker or sign with no exponent digits
                open_span(KindInvalid);
                offer = 1'b1;
            end else begin
                produced         = 1'b1;
                res.kind         = (has_point || has_exp) ? KindFloat : KindInt;
                res.token_length = span_len;
                back_to_idle();
            end
        end else if (lit_mode == ModeError) begin
            offer = 1'b1;
        end

        // error span swallows word characters, points and separators
        if (offer) begin
            if (word_char(ch) || ch == ChPoint || ch == ChUnderscore) begin
                lengthen();
            end else begin
                produced         = 1'b1;
                res.kind         = span_kind;
                res.token_length = span_len;
                back_to_idle();
            end
        end
    endtask

    // watch both channels; result beat is checked before the input beat is predicted
    always @(posedge i_clk) begin : watch
        bit        produced;
        t_out_item res;
        t_out_item due;
        if (!i_rst_n) begin
            due_q.delete();
            back_to_idle();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_q.size() == 0) begin
                    if (fails < 10) begin
                        $display("%0t: unexpected result beat kind %0d length %0d", $time,
                                 i_out_data.kind, i_out_data.token_length);
                    end
                    fails++;
                end else begin
                    due = due_q.pop_front();
                    if (due.kind != i_out_data.kind
                            || due.token_length != i_out_data.token_length) begin
                        if (fails < 10) begin
                            $display({"%0t: result mismatch kind exp %0d got %0d,",
                                      " length exp %0d got %0d"},
                                     $time, due.kind, i_out_data.kind,
                                     due.token_length, i_out_data.token_length);
                        end
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                scan_beat(i_in_data, produced, res);
                if (produced) begin
                    due_q.push_back(res);
                end
            end
        end
        o_fail_count  <= fails;
        o_results_due <= due_q.size();
    end

endmodule

[bench/tb_numeric_literal_scanner_core.sv]
// testbench top for the numeric literal scanner: character stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_numeric_literal_scanner_core;
    import nls_pkg::*;

    localparam int IdleLimit  = 5000;
    localparam int ItemTarget = 1450;
    localparam int HoldCycles = 300;

    localparam logic [7:0] ChNul    = 8'h00;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChComma  = 8'h2C;
    localparam logic [7:0] ChSemi   = 8'h3B;
    localparam logic [7:0] ChParen  = 8'h29;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChLowerA = 8'h61;
    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChLowerX = 8'h78;
    localparam logic [7:0] ChTop    = 8'hFF;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_item  i_data  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;

    int fail_count;
    int results_due;
    int char_count   = 0;
    bit steady_send  = 1'b0;
    bit steady_take  = 1'b0;
    bit hold_off_req = 1'b0;
    bit sending_done = 1'b0;

    always #6 i_clk = ~i_clk;

    numeric_literal_scanner_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    nls_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_data    (o_data),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        int t;
        t = $urandom_range(lo, hi);
        return t[7:0];
    endfunction

    function automatic logic [7:0] dec(input int n);
        return ChZero + n[7:0];
    endfunction

    function automatic logic [7:0] any_letter();
        return ($urandom_range(0, 1) ? ChLowerA : ChUpperA) + rand_byte(0, 25);
    endfunction

    // characters inside a literal body, weighted towards well-formed numbers
    function automatic logic [7:0] body_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 48) return dec($urandom_range(0, 9));
        if (r < 60) return ChUnderscore;
        if (r < 67) return ChPoint;
        if (r < 73) return $urandom_range(0, 1) ? ChLowerE : ChUpperE;
        if (r < 80) return $urandom_range(0, 1) ? ChPlus : ChMinus;
        if (r < 88) return any_letter();
        return rand_byte(0, 255);
    endfunction

    function automatic logic [7:0] end_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return ChSpace;
        if (r < 40) return ChNul;
        if (r < 55) return ChComma;
        if (r < 65) return ChSemi;
        if (r < 75) return ChParen;
        return rand_byte(0, 255);
    endfunction

    // sender gap after a beat: mostly none or short, a few long
    task automatic send_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (steady_send || r < 60) n = 0;
        else if (r < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(4, 30);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic put_char(input logic start, input logic [7:0] ch, input bit counts = 1'b1);
        i_valid <= 1'b1;
        i_data  <= '{cmd: start, char_code: ch};
        do @(posedge i_clk); while (o_stall);
        if (counts) char_count++;
        send_gap();
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    task automatic send_literal(input int body_len);
        int k;
        if ($urandom_range(0, 9) != 0) put_char(1'b1, dec($urandom_range(0, 9)));
        else put_char(1'b1, rand_byte(0, 255));
        for (k = 0; k < body_len; k++) put_char(1'b0, body_char());
        // most literals end on a terminator, others are cut short by the next start
        if ($urandom_range(0, 4) != 0) put_char(1'b0, end_char());
    endtask

    // literal and error span long enough to hit the length cap
    task automatic send_long_runs();
        int k;
        put_char(1'b1, dec(7));
        for (k = 0; k < 280; k++) put_char(1'b0, (k % 5 == 3) ? ChUnderscore : dec(k % 10));
        put_char(1'b0, ChSpace);
        put_char(1'b1, dec(1));
        put_char(1'b0, ChUnderscore);
        put_char(1'b0, ChUnderscore);
        for (k = 0; k < 280; k++) put_char(1'b0, ($urandom_range(0, 9) == 0) ? ChPoint : any_letter());
        put_char(1'b0, ChSemi);
    endtask

    // stimulus
    initial begin
        int r;
        int k;
        int long_done;
        long_done = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain integer
        put_char(1'b1, dec(9)); put_char(1'b0, dec(0)); put_char(1'b0, ChSpace);
        // leading point is not a number
        put_char(1'b1, ChPoint);
        // float with point, marker and sign, ended by a NUL character
        put_char(1'b1, dec(1)); put_char(1'b0, ChPoint); put_char(1'b0, ChUpperE);
        put_char(1'b0, ChPlus); put_char(1'b0, dec(7)); put_char(1'b0, ChNul);
        // doubled separator, span closed by a high character
        put_char(1'b1, dec(1)); put_char(1'b0, ChUnderscore); put_char(1'b0, ChUnderscore);
        put_char(1'b0, ChTop);
        // separator straight after the exponent marker, span swallows a letter
        put_char(1'b1, dec(2)); put_char(1'b0, ChLowerE); put_char(1'b0, ChUnderscore);
        put_char(1'b0, ChLowerX); put_char(1'b0, ChSemi);
        // trailing separator
        put_char(1'b1, dec(3)); put_char(1'b0, ChUnderscore); put_char(1'b0, ChComma);
        // incomplete exponent
        put_char(1'b1, dec(4)); put_char(1'b0, ChLowerE); put_char(1'b0, ChSpace);
        // continue while idle is ignored
        put_char(1'b0, dec(5), 1'b0);
        // start while busy, then a second point ends the literal
        put_char(1'b1, dec(6)); put_char(1'b1, dec(7)); put_char(1'b0, ChPoint);
        put_char(1'b0, ChPoint);
        wait_drained();

        // random literals, the receiver holds off for a long stretch early on
        hold_off_req = 1'b1;
        while (char_count < ItemTarget) begin
            if ($urandom_range(0, 19) == 0) steady_send = ~steady_send;
            if ((char_count > 400 && long_done == 0) || (char_count > 900 && long_done == 1)) begin
                long_done++;
                send_long_runs();
                if (long_done == 1) wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_literal($urandom_range(0, 8));
            end else if (r < 90) begin
                send_literal($urandom_range(9, 20));
            end else begin
                // noise: random commands and characters
                for (k = $urandom_range(1, 3); k > 0; k--) begin
                    if ($urandom_range(0, 1)) put_char(1'b1, rand_byte(0, 255));
                    else put_char(1'b0, rand_byte(0, 255), 1'b0);
                end
            end
        end

        sending_done = 1'b1;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // receiver stalls: random gaps, one long hold-off, free running at the end
    initial begin
        int r;
        int n;
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        while (!sending_done) begin
            if (hold_off_req && !held) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                if ($urandom_range(0, 29) == 0) steady_take = ~steady_take;
                r = $urandom_range(0, 99);
                if (r < 85) n = $urandom_range(1, 3);
                else n = $urandom_range(5, 25);
                i_stall <= !steady_take && ($urandom_range(0, 99) < 35);
                repeat (n) @(posedge i_clk);
            end
        end
        i_stall <= 1'b0;
    end

    // watchdog on cycles with no beat accepted on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IdleLimit) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule
